// ===== design/variable_partition_allocator_macros.svh =====
// Assertion macros for the variable partition allocator.
// Included by the top level; no other dependencies.
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define VPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/vpa_pkg.sv =====
// Package for the variable partition allocator: status, command, policy and
// free-chain cell operation codes. No dependencies.
`default_nettype none
package vpa_pkg;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic       CMD_STORE  = 1'b0;
    localparam logic       CMD_REVOKE = 1'b1;
    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_NEXT   = 2'd1;
    localparam logic [1:0] POL_BEST   = 2'd2;
    localparam logic [1:0] POL_RSVD   = 2'd3;   // behaves as first fit
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LOAD  = 2'd1;
    localparam logic [1:0] CELL_LEFT  = 2'd2;
    localparam logic [1:0] CELL_RIGHT = 2'd3;
endpackage
`default_nettype wire

// ===== design/vpa_if.sv =====
// Channel interfaces for the allocator: command, result, configuration.
// Standalone; widths fixed by the field definitions.
`default_nettype none
interface vpa_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] job_id;
    logic [7:0] job_size;
    modport source (output valid, cmd, job_id, job_size, input ready);
    modport sink   (input valid, cmd, job_id, job_size, output ready);
endinterface

interface vpa_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] block_start;
    logic [3:0] free_segments;
    modport source (output valid, status, block_start, free_segments, input ready);
    modport sink   (input valid, status, block_start, free_segments, output ready);
endinterface

interface vpa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/vpa_cell.sv =====
// One cell of the free-segment chain: holds a segment, shifts with neighbors.
// Depends on vpa_pkg for the cell operation codes.
`default_nettype none
module vpa_cell #(
    parameter int AW = 7
) (
    input  wire logic          clk,
    input  wire logic [1:0]    op,      // hold, load, take left, take right
    input  wire logic [AW:0]   ld_start,
    input  wire logic [AW:0]   ld_size,
    input  wire logic [AW:0]   left_start,
    input  wire logic [AW:0]   left_size,
    input  wire logic [AW:0]   right_start,
    input  wire logic [AW:0]   right_size,
    output logic      [AW:0]   seg_start,
    output logic      [AW:0]   seg_size
);
    import vpa_pkg::*;

    logic [AW:0] start_reg, size_reg;
    always_ff @(posedge clk)
    begin
        unique case (op)
            CELL_HOLD:
            begin
                start_reg <= start_reg;
                size_reg  <= size_reg;
            end
            CELL_LOAD:
            begin
                start_reg <= ld_start;
                size_reg  <= ld_size;
            end
            CELL_LEFT:
            begin
                start_reg <= left_start;
                size_reg  <= left_size;
            end
            CELL_RIGHT:
            begin
                start_reg <= right_start;
                size_reg  <= right_size;
            end
        endcase
    end
    assign seg_start = start_reg;
    assign seg_size  = size_reg;
endmodule
`default_nettype wire

// ===== design/variable_partition_allocator.sv =====
// Variable partition allocator, one command at a time. The result beat follows the
// command beat after a job scan over MAX_JOBS slots, a free-chain scan over MAX_JOBS+1
// cells, an update state and a result load, with a shift state before the load when the
// chain shifts. The next command is taken the cycle after the result loads; an unread
// result stalls only the next command's result load. Reset (rst_n, async) leaves one
// free segment over the memory, no jobs, next-fit pointer 0, first fit; ready follows
// once the init pass has reloaded cell 0.
`default_nettype none
`include "variable_partition_allocator_macros.svh"
module variable_partition_allocator #(
    parameter int MEM_SIZE = 128,
    parameter int MAX_JOBS = 8
) (
    input wire logic clk,
    input wire logic rst_n,
    vpa_cmd_if.sink   cmd_ch,
    vpa_res_if.source res_ch,
    vpa_cfg_if.sink   cfg_ch
);
    import vpa_pkg::*;

    localparam int AW = $clog2(MEM_SIZE);      // address bits; sizes use AW+1
    localparam int FD = MAX_JOBS + 1;          // free chain depth
    localparam int FW = $clog2(FD + 1);        // free count width
    localparam int JW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(FD + 1);        // scan counter width
    localparam int SW = (AW + 1 > 8) ? AW + 1 : 8;  // request vs segment compare width

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_JOBS  = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // ---- configuration ----
    logic [1:0] policy_reg;
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) policy_reg <= POL_FIRST;
        else if (cfg_ch.valid) policy_reg <= cfg_ch.data;
    end

    // ---- job table (flip-flop slots, scanned one per cycle) ----
    logic            jv_reg [MAX_JOBS];
    logic [7:0]      jid_reg [MAX_JOBS];
    logic [AW-1:0]   jst_reg [MAX_JOBS];
    logic [AW:0]     jsz_reg [MAX_JOBS];

    // ---- control ----
    logic [2:0]    state_reg;
    logic [CW-1:0] idx_reg;
    logic          cmd_reg;
    logic [7:0]    id_reg;
    logic [7:0]    size_reg;
    logic          found_reg, slot_ok_reg;
    logic [JW-1:0] found_reg_i, slot_reg;
    logic [FW-1:0] cnt_reg;
    logic [CW-1:0] nfp_reg;
    // free scan results
    logic          k_ok_reg, nx_ok_reg;
    logic [CW-1:0] k_reg, nx_reg;
    logic [AW:0]   best_sz_reg;
    logic          lo_ok_reg, hi_ok_reg;
    logic [CW-1:0] lo_reg, hi_reg, pos_reg;
    logic [AW:0]   ws_reg, wsz_reg;
    // shift pass
    logic [CW-1:0] sh_at_reg;
    logic          sh_dir_reg;   // 1 = open gap at sh_at (shift right), 0 = close
    // result of the command in work, held until the output register is free
    logic [2:0]    ust_reg;
    logic [6:0]    ustart_reg;
    // result
    logic          rv_reg;
    logic [2:0]    rst_reg;
    logic [6:0]    rstart_reg;
    logic [3:0]    rfree_reg;

    // ---- free chain ----
    logic [1:0]  cop   [FD];
    logic [AW:0] cst   [FD];
    logic [AW:0] csz   [FD];
    logic [AW:0] ldst, ldsz;
    logic [CW-1:0] ld_at;
    logic        ld_en;

    genvar g;
    generate
        for (g = 0; g < FD; g++)
        begin : g_cell
            vpa_cell #(.AW(AW)) u_cell (
                .clk        (clk),
                .op         (cop[g]),
                .ld_start   (ldst),
                .ld_size    (ldsz),
                .left_start ((g == 0) ? cst[0] : cst[(g == 0) ? 0 : g - 1]),
                .left_size  ((g == 0) ? csz[0] : csz[(g == 0) ? 0 : g - 1]),
                .right_start((g == FD - 1) ? cst[g] : cst[(g == FD - 1) ? g : g + 1]),
                .right_size ((g == FD - 1) ? csz[g] : csz[(g == FD - 1) ? g : g + 1]),
                .seg_start  (cst[g]),
                .seg_size   (csz[g])
            );
        end
    endgenerate

    // reset pass: cell 0 reloaded from init flag
    logic init_reg;

    // current scan cell
    logic [AW:0] sc_st, sc_sz, sc_end;
    always_comb
    begin
        sc_st = '0;
        sc_sz = '0;
        for (int i = 0; i < FD; i++)
        begin
            if (idx_reg == CW'(i))
            begin
                sc_st = cst[i];
                sc_sz = csz[i];
            end
        end
        sc_end = sc_st + sc_sz;
    end

    logic [AW:0] need;
    assign need = (AW + 1)'(size_reg);   // only used once the request fits
    logic fits;
    assign fits = SW'(size_reg) <= SW'(sc_sz);

    // selected segment for store
    logic [CW-1:0] k_sel;
    logic          k_sel_ok;
    always_comb
    begin
        if (policy_reg == POL_NEXT)
        begin
            k_sel_ok = nx_ok_reg || k_ok_reg;
            k_sel    = nx_ok_reg ? nx_reg : k_reg;
        end
        else
        begin
            k_sel_ok = k_ok_reg;
            k_sel    = k_reg;
        end
    end

    logic [AW:0] ksz, kst, losz, hisz;
    always_comb
    begin
        ksz = '0; kst = '0; losz = '0; hisz = '0;
        for (int i = 0; i < FD; i++)
        begin
            if (k_sel == CW'(i)) begin ksz = csz[i]; kst = cst[i]; end
            if (lo_reg == CW'(i)) losz = csz[i];
            if (hi_reg == CW'(i)) hisz = csz[i];
        end
    end

    assign cmd_ch.ready   = (state_reg == S_IDLE) && !init_reg;
    assign res_ch.valid   = rv_reg;
    assign res_ch.status  = rst_reg;
    assign res_ch.block_start   = rstart_reg;
    assign res_ch.free_segments = rfree_reg;

    // chain ops
    always_comb
    begin
        for (int i = 0; i < FD; i++) cop[i] = CELL_HOLD;
        ldst = '0; ldsz = '0; ld_at = '0; ld_en = 1'b0;
        if (init_reg)
        begin
            ld_en = 1'b1; ld_at = '0; ldst = '0; ldsz = (AW + 1)'(MEM_SIZE);
        end
        else if (state_reg == S_UPD)
        begin
            if (cmd_reg == CMD_STORE)
            begin
                if (found_reg || !slot_ok_reg || size_reg == 8'd0 || !k_sel_ok) ld_en = 1'b0;
                else if (need != ksz)
                begin
                    ld_en = 1'b1; ld_at = k_sel; ldst = kst + need; ldsz = ksz - need;
                end
            end
            else if (found_reg)
            begin
                if (lo_ok_reg)
                begin
                    ld_en = 1'b1; ld_at = lo_reg;
                    ldst = ws_reg - losz; // unchanged start
                    ldsz = losz + wsz_reg + (hi_ok_reg ? hisz : '0);
                    for (int i = 0; i < FD; i++)
                        if (lo_reg == CW'(i)) ldst = cst[i];
                end
                else if (hi_ok_reg)
                begin
                    ld_en = 1'b1; ld_at = hi_reg; ldst = ws_reg; ldsz = hisz + wsz_reg;
                end
            end
        end
        else if (state_reg == S_SHIFT && sh_dir_reg)
        begin
            ld_en = 1'b1; ld_at = sh_at_reg; ldst = ws_reg; ldsz = wsz_reg;
        end
        for (int i = 0; i < FD; i++)
        begin
            if (state_reg == S_SHIFT && !init_reg)
            begin
                if (sh_dir_reg && CW'(i) > sh_at_reg) cop[i] = CELL_LEFT;
                if (!sh_dir_reg && CW'(i) >= sh_at_reg && i < FD - 1) cop[i] = CELL_RIGHT;
            end
            if (ld_en && ld_at == CW'(i)) cop[i] = CELL_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; init_reg <= 1'b1; cnt_reg <= FW'(1); nfp_reg <= '0;
            rv_reg <= 1'b0; idx_reg <= '0;
            for (int i = 0; i < MAX_JOBS; i++) jv_reg[i] <= 1'b0;
        end
        else
        begin
            init_reg <= 1'b0;
            if (rv_reg && res_ch.ready) rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_ch.valid && cmd_ch.ready)
                    begin
                        cmd_reg <= cmd_ch.cmd; id_reg <= cmd_ch.job_id;
                        size_reg <= cmd_ch.job_size;
                        found_reg <= 1'b0; slot_ok_reg <= 1'b0;
                        idx_reg <= '0; state_reg <= S_JOBS;
                    end
                end
                S_JOBS:
                begin
                    for (int i = 0; i < MAX_JOBS; i++)
                    begin
                        if (idx_reg == CW'(i))
                        begin
                            if (jv_reg[i] && jid_reg[i] == id_reg)
                            begin
                                found_reg <= 1'b1; found_reg_i <= JW'(i);
                                ws_reg <= {1'b0, jst_reg[i]}; wsz_reg <= jsz_reg[i];
                            end
                            else if (!jv_reg[i] && !slot_ok_reg)
                            begin
                                slot_ok_reg <= 1'b1; slot_reg <= JW'(i);
                            end
                        end
                    end
                    if (idx_reg == CW'(MAX_JOBS - 1))
                    begin
                        idx_reg <= '0; state_reg <= S_FREE;
                        k_ok_reg <= 1'b0; nx_ok_reg <= 1'b0;
                        lo_ok_reg <= 1'b0; hi_ok_reg <= 1'b0; pos_reg <= '0;
                    end
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_FREE:
                begin
                    if (idx_reg < CW'(cnt_reg))
                    begin
                        if (fits)
                        begin
                            if (policy_reg == POL_BEST)
                            begin
                                if (!k_ok_reg || sc_sz < best_sz_reg)
                                begin
                                    k_ok_reg <= 1'b1; k_reg <= idx_reg; best_sz_reg <= sc_sz;
                                end
                            end
                            else if (!k_ok_reg)
                            begin
                                k_ok_reg <= 1'b1; k_reg <= idx_reg;
                            end
                            if (idx_reg > nfp_reg && !nx_ok_reg)
                            begin
                                nx_ok_reg <= 1'b1; nx_reg <= idx_reg;
                            end
                        end
                        if (sc_end <= ws_reg) pos_reg <= idx_reg + 1'b1;
                        if (sc_end == ws_reg) begin lo_ok_reg <= 1'b1; lo_reg <= idx_reg; end
                        if (sc_st == ws_reg + wsz_reg)
                        begin
                            hi_ok_reg <= 1'b1; hi_reg <= idx_reg;
                        end
                    end
                    if (idx_reg == CW'(FD - 1)) state_reg <= S_UPD;
                    else idx_reg <= idx_reg + 1'b1;
                end
                S_UPD:
                begin
                    if (cmd_reg == CMD_STORE)
                    begin
                        if (size_reg == 8'd0)
                        begin
                            ust_reg <= ST_ZERO; ustart_reg <= '0; state_reg <= S_OUT;
                        end
                        else if (found_reg || !slot_ok_reg)
                        begin
                            ust_reg <= ST_FULL; ustart_reg <= '0; state_reg <= S_OUT;
                        end
                        else if (!k_sel_ok)
                        begin
                            ust_reg <= ST_NOFIT; ustart_reg <= '0; state_reg <= S_OUT;
                        end
                        else
                        begin
                            ust_reg <= ST_OK;
                            ustart_reg <= 7'(kst);
                            for (int i = 0; i < MAX_JOBS; i++)
                                if (slot_reg == JW'(i))
                                begin
                                    jv_reg[i] <= 1'b1; jid_reg[i] <= id_reg;
                                    jst_reg[i] <= kst[AW-1:0]; jsz_reg[i] <= need;
                                end
                            if (policy_reg == POL_NEXT) nfp_reg <= k_sel;
                            if (need == ksz)
                            begin
                                sh_dir_reg <= 1'b0; sh_at_reg <= k_sel;
                                cnt_reg <= cnt_reg - 1'b1; state_reg <= S_SHIFT;
                            end
                            else state_reg <= S_OUT;
                        end
                    end
                    else if (!found_reg)
                    begin
                        ust_reg <= ST_UNKNOWN; ustart_reg <= '0; state_reg <= S_OUT;
                    end
                    else
                    begin
                        ust_reg <= ST_OK;
                        ustart_reg <= 7'(ws_reg);
                        for (int i = 0; i < MAX_JOBS; i++)
                            if (found_reg_i == JW'(i)) jv_reg[i] <= 1'b0;
                        if (lo_ok_reg && hi_ok_reg)
                        begin
                            sh_dir_reg <= 1'b0; sh_at_reg <= hi_reg;
                            cnt_reg <= cnt_reg - 1'b1; state_reg <= S_SHIFT;
                        end
                        else if (!lo_ok_reg && !hi_ok_reg && cnt_reg < FW'(FD))
                        begin
                            sh_dir_reg <= 1'b1; sh_at_reg <= pos_reg;
                            cnt_reg <= cnt_reg + 1'b1; state_reg <= S_SHIFT;
                        end
                        else state_reg <= S_OUT;
                    end
                end
                S_SHIFT:
                begin
                    state_reg <= S_OUT;
                end
                default:
                begin
                    // S_OUT: load result register once the previous beat has left
                    if (!rv_reg)
                    begin
                        rv_reg <= 1'b1;
                        rst_reg <= ust_reg;
                        rstart_reg <= ustart_reg;
                        rfree_reg <= 4'(cnt_reg);
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `VPA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= FW'(FD), "free count above depth")
    `VPA_ASSERT_NXT(a_accept_scan, cmd_ch.valid && cmd_ch.ready, state_reg == S_JOBS,
        "accepted beat did not start the job scan")
    `VPA_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, !cmd_ch.ready,
        "command ready while busy")
endmodule
`default_nettype wire
